/* hdl/injection_fill_pack_sequencer_top_assert.svh */
// Assertion macros for the injection fill/pack sequencer.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef INJECTION_FILL_PACK_SEQUENCER_TOP_ASSERT_SVH
`define INJECTION_FILL_PACK_SEQUENCER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define IFPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, disabled during reset
`define IFPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define IFPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define IFPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* hdl/ifps_pkg.sv */
// Shared types and constants for the injection fill/pack sequencer.
// No dependencies.
package ifps_pkg;

	// input kinds
	localparam logic [1:0] KIND_BEGIN  = 2'd0;
	localparam logic [1:0] KIND_UPDATE = 2'd1;
	localparam logic [1:0] KIND_RESET  = 2'd2;

	// command kinds
	localparam logic [1:0] CMD_NONE   = 2'd0;
	localparam logic [1:0] CMD_LIMITS = 2'd1;
	localparam logic [1:0] CMD_TRAJ   = 2'd2;
	localparam logic [1:0] CMD_MOVE   = 2'd3;

	// command profiles
	localparam logic [1:0] PROF_FILL = 2'd0;
	localparam logic [1:0] PROF_PACK = 2'd1;
	localparam logic [1:0] PROF_STOP = 2'd2;

	// phases
	localparam logic [1:0] PH_DONE = 2'd0;
	localparam logic [1:0] PH_FILL = 2'd1;
	localparam logic [1:0] PH_PACK = 2'd2;

	// tail group of a job, after the optional fill entry commands
	localparam logic [1:0] GRP_NONE = 2'd0;
	localparam logic [1:0] GRP_PACK = 2'd1;
	localparam logic [1:0] GRP_STOP = 2'd2;

	// register indexes
	localparam logic [2:0] REG_FILL_VOLUME  = 3'd0;
	localparam logic [2:0] REG_PACK_VOLUME  = 3'd1;
	localparam logic [2:0] REG_PACK_TIME    = 3'd2;
	localparam logic [2:0] REG_TURNS_PER_VOL = 3'd3;
	localparam logic [2:0] REG_POS_LIMIT    = 3'd4;
	localparam logic [2:0] REG_FILL_TRAJ    = 3'd5;
	localparam logic [2:0] REG_PACK_TRAJ    = 3'd6;

	localparam int CFG_DATA_W = 48;

	// thresholds
	localparam logic signed [31:0] VEL_LOW_MAX     = 32'sd6553;
	localparam logic signed [32:0] POS_CLOSE_LIM   = 33'sd65536;
	localparam logic [31:0]        SETTLE_MS       = 32'd500;
	localparam logic [31:0]        FILL_TIMEOUT_MS = 32'd30000;

	// beats per command set, and the most beats one item gives
	localparam logic [2:0] SET_BEATS = 3'd3;
	localparam logic [2:0] MAX_BEATS = 3'd6;

	typedef struct packed {
		logic [1:0]         kind;
		logic [31:0]        now_ms;
		logic signed [31:0] position;
		logic signed [31:0] velocity;
	} ifps_in_t;

	typedef struct packed {
		logic [1:0]         cmd_kind;
		logic [1:0]         profile;
		logic signed [31:0] move_target;
		logic [47:0]        traj_word;
		logic [1:0]         phase;
		logic               finished;
		logic               complete_ok;
		logic               error;
		logic               last;
	} ifps_out_t;

	// registered configuration, volume products already scaled to Q16.16
	typedef struct packed {
		logic [15:0]        pack_time_ms;
		logic signed [31:0] position_limit;
		logic [47:0]        fill_trajectory;
		logic [47:0]        pack_trajectory;
		logic [31:0]        fill_add;
		logic [31:0]        pack_add;
	} ifps_cfg_t;

	// one classified item on its way to the command sequencer
	typedef struct packed {
		logic               entry;
		logic [1:0]         grp;
		logic signed [31:0] fill_target;
		logic signed [31:0] pack_target;
		logic [1:0]         phase;
		logic               finished;
		logic               complete_ok;
		logic               error;
	} ifps_job_t;

endpackage

/* hdl/injection_fill_pack_sequencer_top.sv */
// Top level of the injection fill/pack sequencer.
// Depends on ifps_pkg, ifps_cfg, ifps_front, ifps_queue and ifps_back.
//
// Accepts one input beat per cycle into the classifier while the job queue is
// not full; it updates the fill/pack state and queues a job, and the command
// sequencer sends the job's results one beat per cycle unless the output stalls.
// A begin, reset or quiet update gives one beat, a fill entry three, an entry
// with a pack transition six, an entry with a timeout stop four; the sustained
// rate is set by the sequencer. A result passes the input register, the job
// queue and the registered output stage. Volume and turns writes take effect
// once the registered volume products update.
module injection_fill_pack_sequencer_top import ifps_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  ifps_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ifps_out_t             out_data
);

	ifps_cfg_t cfg;
	ifps_job_t push_job;
	ifps_job_t head;
	logic      push;
	logic      pop;
	logic      q_full;
	logic      q_empty;

	ifps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ifps_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cfg      (cfg),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	ifps_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	ifps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.cfg       (cfg),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

/* hdl/ifps_cfg.sv */
// Configuration register file with registered volume-times-turns products.
// Depends on ifps_pkg.
module ifps_cfg import ifps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output ifps_cfg_t             cfg
);

	logic [23:0]        fill_volume_q;
	logic [23:0]        pack_volume_q;
	logic [15:0]        pack_time_q;
	logic [23:0]        turns_q;
	logic signed [31:0] limit_q;
	logic [47:0]        fill_traj_q;
	logic [47:0]        pack_traj_q;
	logic [31:0]        fill_add_q;
	logic [31:0]        pack_add_q;
	logic [47:0]        fill_prod;
	logic [47:0]        pack_prod;

	assign fill_prod = fill_volume_q * turns_q;
	assign pack_prod = pack_volume_q * turns_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_volume_q <= '0;
			pack_volume_q <= '0;
			pack_time_q   <= '0;
			turns_q       <= 24'd65536;
			limit_q       <= 32'sh7FFF_FFFF;
			fill_traj_q   <= '0;
			pack_traj_q   <= '0;
			fill_add_q    <= '0;
			pack_add_q    <= '0;
		end else begin
			// Q8.16 x Q8.16, floored back to Q16.16
			fill_add_q <= fill_prod[47:16];
			pack_add_q <= pack_prod[47:16];
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FILL_VOLUME:   fill_volume_q <= cfg_data[23:0];
					REG_PACK_VOLUME:   pack_volume_q <= cfg_data[23:0];
					REG_PACK_TIME:     pack_time_q   <= cfg_data[15:0];
					REG_TURNS_PER_VOL: turns_q       <= cfg_data[23:0];
					REG_POS_LIMIT:     limit_q       <= signed'(cfg_data[31:0]);
					REG_FILL_TRAJ:     fill_traj_q   <= cfg_data;
					REG_PACK_TRAJ:     pack_traj_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	assign cfg.pack_time_ms    = pack_time_q;
	assign cfg.position_limit  = limit_q;
	assign cfg.fill_trajectory = fill_traj_q;
	assign cfg.pack_trajectory = pack_traj_q;
	assign cfg.fill_add        = fill_add_q;
	assign cfg.pack_add        = pack_add_q;

endmodule

/* hdl/ifps_front.sv */
// Front end: takes input beats, holds the sequencer state and classifies each
// item into a job for the command queue. Depends on ifps_pkg.
module ifps_front import ifps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  ifps_in_t  in_data,
	input  ifps_cfg_t cfg,
	input  logic      q_full,
	output logic      push,
	output ifps_job_t push_job
);

	function automatic logic is_close(input logic signed [32:0] d);
		return (d > -POS_CLOSE_LIM) && (d < POS_CLOSE_LIM);
	endfunction

	ifps_in_t           item_s1;
	logic               valid_s1;

	logic [1:0]         phase_q;
	logic               pending_q;
	logic               complete_q;
	logic               error_q;
	logic [31:0]        start_q;
	logic signed [31:0] fill_tgt_q;
	logic signed [31:0] pack_tgt_q;

	logic [1:0]         phase_d;
	logic               pending_d;
	logic               complete_d;
	logic               error_d;
	logic [31:0]        start_d;
	logic signed [31:0] fill_tgt_d;
	logic signed [31:0] pack_tgt_d;
	logic               fin;
	logic [1:0]         grp;
	logic               entry;

	logic signed [33:0] lim_x;
	logic signed [33:0] ft_sum;
	logic signed [33:0] pt_sum;
	logic               ft_clamp;
	logic               pt_clamp;
	logic signed [31:0] ft_new;
	logic signed [31:0] pt_new;
	logic               close_new;
	logic               close_old;
	logic               close;
	logic               vel_ok;
	logic [31:0]        elapsed;

	assign in_stall = valid_s1 && q_full;
	assign push     = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// candidate targets; both clamp from above only
	assign lim_x    = {{2{cfg.position_limit[31]}}, cfg.position_limit};
	assign ft_sum   = {{2{item_s1.position[31]}}, item_s1.position} + {2'b00, cfg.fill_add};
	assign pt_sum   = {{2{item_s1.position[31]}}, item_s1.position} + {2'b00, cfg.pack_add};
	assign ft_clamp = ft_sum > lim_x;
	assign pt_clamp = pt_sum > lim_x;
	assign ft_new   = ft_clamp ? cfg.position_limit : ft_sum[31:0];
	assign pt_new   = pt_clamp ? cfg.position_limit : pt_sum[31:0];

	// distance to a fresh fill target without chaining add and subtract:
	// unclamped it is minus the added volume, clamped it is position minus limit
	assign close_new = ft_clamp ?
		is_close({item_s1.position[31], item_s1.position} -
			{cfg.position_limit[31], cfg.position_limit}) :
		(cfg.fill_add < 32'(POS_CLOSE_LIM));
	assign close_old = is_close({item_s1.position[31], item_s1.position} -
		{fill_tgt_q[31], fill_tgt_q});
	assign close     = pending_q ? close_new : close_old;
	assign vel_ok    = (item_s1.velocity >= -VEL_LOW_MAX) && (item_s1.velocity <= VEL_LOW_MAX);
	assign elapsed   = item_s1.now_ms - start_q;

	always_comb begin
		phase_d    = phase_q;
		pending_d  = pending_q;
		complete_d = complete_q;
		error_d    = error_q;
		start_d    = start_q;
		fill_tgt_d = fill_tgt_q;
		pack_tgt_d = pack_tgt_q;
		fin        = 1'b0;
		grp        = GRP_NONE;
		entry      = 1'b0;
		case (item_s1.kind)
			KIND_BEGIN: begin
				phase_d    = PH_FILL;
				pending_d  = 1'b1;
				start_d    = item_s1.now_ms;
				complete_d = 1'b0;
				error_d    = 1'b0;
			end
			KIND_RESET: begin
				phase_d    = PH_DONE;
				pending_d  = 1'b1;
				complete_d = 1'b0;
				error_d    = 1'b0;
			end
			KIND_UPDATE: begin
				if (pending_q) begin
					entry      = 1'b1;
					fill_tgt_d = ft_new;
					pending_d  = 1'b0;
				end
				case (phase_q)
					PH_FILL: begin
						if (vel_ok && (elapsed > SETTLE_MS) && close) begin
							phase_d    = PH_PACK;
							start_d    = item_s1.now_ms;
							pack_tgt_d = pt_new;
							grp        = GRP_PACK;
						end else if (elapsed > FILL_TIMEOUT_MS) begin
							error_d    = 1'b1;
							complete_d = 1'b1;
							grp        = GRP_STOP;
							fin        = 1'b1;
						end
					end
					PH_PACK: begin
						if (elapsed >= {16'd0, cfg.pack_time_ms}) begin
							phase_d    = PH_DONE;
							complete_d = 1'b1;
							fin        = 1'b1;
						end
					end
					default: fin = complete_q;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_DONE;
			pending_q  <= 1'b0;
			complete_q <= 1'b0;
			error_q    <= 1'b0;
			start_q    <= '0;
			fill_tgt_q <= '0;
			pack_tgt_q <= '0;
		end else if (push) begin
			phase_q    <= phase_d;
			pending_q  <= pending_d;
			complete_q <= complete_d;
			error_q    <= error_d;
			start_q    <= start_d;
			fill_tgt_q <= fill_tgt_d;
			pack_tgt_q <= pack_tgt_d;
		end
	end

	assign push_job.entry       = entry;
	assign push_job.grp         = grp;
	assign push_job.fill_target = fill_tgt_d;
	assign push_job.pack_target = pack_tgt_d;
	assign push_job.phase       = phase_d;
	assign push_job.finished    = fin;
	assign push_job.complete_ok = complete_d && !error_d;
	assign push_job.error       = error_d;

endmodule

/* hdl/ifps_queue.sv */
// Short job queue between the classifier and the command sequencer.
// Depends on ifps_pkg.
module ifps_queue import ifps_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  ifps_job_t push_job,
	input  logic      pop,
	output ifps_job_t head,
	output logic      full,
	output logic      empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ifps_job_t          slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   count_q;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full  = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/ifps_back.sv */
// Back end: expands each queued job into its command beats, one per cycle unless
// stalled, through a registered output stage. Depends on ifps_pkg and the assert macros.
`include "injection_fill_pack_sequencer_top_assert.svh"
module ifps_back import ifps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ifps_job_t head,
	input  logic      empty,
	output logic      pop,
	input  ifps_cfg_t cfg,
	output logic      out_valid,
	input  logic      out_stall,
	output ifps_out_t out_data
);

	logic [2:0]  beat_q;
	logic        out_valid_q;
	ifps_out_t   out_q;
	logic        load;
	logic [2:0]  n_entry;
	logic [2:0]  n_tail;
	logic [2:0]  total;
	logic [2:0]  sub;
	logic        in_entry;
	logic [1:0]  prof;
	logic signed [31:0] tgt;
	logic [47:0] traj;
	ifps_out_t   beat;

	assign load    = !empty && (!out_valid_q || !out_stall);
	assign n_entry = head.entry ? SET_BEATS : 3'd0;
	always_comb begin
		case (head.grp)
			GRP_PACK: n_tail = SET_BEATS;
			GRP_STOP: n_tail = 3'd1;
			default:  n_tail = 3'd0;
		endcase
	end
	// an item with no command still gives one empty beat
	assign total    = ((n_entry + n_tail) == 3'd0) ? 3'd1 : n_entry + n_tail;
	assign in_entry = head.entry && (beat_q < SET_BEATS);
	assign sub      = in_entry ? beat_q : beat_q - n_entry;
	assign pop      = load && (beat_q == total - 3'd1);

	always_comb begin
		prof = in_entry ? PROF_FILL : PROF_PACK;
		tgt  = in_entry ? head.fill_target : head.pack_target;
		traj = in_entry ? cfg.fill_trajectory : cfg.pack_trajectory;
		beat = '0;
		beat.phase       = head.phase;
		beat.finished    = head.finished;
		beat.complete_ok = head.complete_ok;
		beat.error       = head.error;
		beat.last        = beat_q == total - 3'd1;
		if (in_entry || head.grp == GRP_PACK) begin
			beat.profile = prof;
			unique case (sub)
				3'd0: beat.cmd_kind = CMD_LIMITS;
				3'd1: begin
					beat.cmd_kind  = CMD_TRAJ;
					beat.traj_word = traj;
				end
				default: begin
					beat.cmd_kind    = CMD_MOVE;
					beat.move_target = tgt;
				end
			endcase
		end else if (head.grp == GRP_STOP) begin
			beat.cmd_kind = CMD_MOVE;
			beat.profile  = PROF_STOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				beat_q      <= pop ? 3'd0 : beat_q + 3'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= beat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`IFPS_ASSERT_IMP(a_beat_range, clk, arst_n, 1'b1, beat_q < MAX_BEATS, "beat index out of range")
	`IFPS_ASSERT_IMP(a_pop_nonempty, clk, arst_n, pop, !empty, "job popped from empty queue")
	`IFPS_ASSERT_IMP(a_none_is_last, clk, arst_n, load && beat.cmd_kind == CMD_NONE, beat.last,
		"empty beat not final")
	`IFPS_ASSERT_NXT(a_pop_rewinds, clk, arst_n, pop, beat_q == 3'd0, "beat index not rewound")

endmodule

/* tb/ifps_cmd_checker.sv */
// Command stream checker for the injection fill/pack sequencer testbench.
// Depends on ifps_pkg; watches the config port and both channels, predicts, compares.
`timescale 1ns / 1ps

module ifps_cmd_checker import ifps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  ifps_in_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  ifps_out_t             out_data,
	output int                    fail_count,
	output int                    pending,
	output int                    beats_seen
);

	// shadow registers
	logic [23:0]        fill_vol, pack_vol, turns_vol;
	logic [15:0]        pack_ms;
	logic signed [31:0] pos_lim;
	logic [47:0]        fill_traj, pack_traj;

	// shadow sequencer state
	logic [1:0]         ph;
	logic               entry_pend, done_flag, err_flag;
	logic [31:0]        ph_start;
	logic signed [31:0] fill_tgt, pack_tgt;

	ifps_out_t cmd_expect_q[$];
	ifps_out_t cmd_batch[$];

	initial fail_count = 0;

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (fail_count < 40)
			$display("ERROR %0t: %s got %0h, want %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic logic signed [31:0] clamp_target(logic signed [31:0] pos,
			logic [23:0] vol);
		logic [47:0] prod;
		longint      t;
		prod = vol * turns_vol;
		t = longint'(pos) + longint'(prod[47:16]);
		if (t > longint'(pos_lim))
			t = longint'(pos_lim);
		return t[31:0];
	endfunction

	function automatic ifps_out_t cmd_beat(logic [1:0] cmd, logic [1:0] prof,
			logic signed [31:0] tgt, logic [47:0] traj);
		ifps_out_t b;
		b = '0;
		b.cmd_kind = cmd;
		b.profile = prof;
		b.move_target = tgt;
		b.traj_word = traj;
		return b;
	endfunction

	task automatic add_cmd_set(logic [1:0] prof, logic signed [31:0] tgt, logic [47:0] traj);
		cmd_batch.push_back(cmd_beat(CMD_LIMITS, prof, '0, '0));
		cmd_batch.push_back(cmd_beat(CMD_TRAJ, prof, '0, traj));
		cmd_batch.push_back(cmd_beat(CMD_MOVE, prof, tgt, '0));
	endtask

	task automatic predict_cmds(ifps_in_t it);
		logic        fin;
		logic [31:0] elapsed;
		longint      av, ad;
		fin = 1'b0;
		case (it.kind)
			KIND_BEGIN: begin
				ph = PH_FILL;
				entry_pend = 1'b1;
				ph_start = it.now_ms;
				done_flag = 1'b0;
				err_flag = 1'b0;
			end
			KIND_RESET: begin
				ph = PH_DONE;
				entry_pend = 1'b1;
				done_flag = 1'b0;
				err_flag = 1'b0;
			end
			KIND_UPDATE: begin
				elapsed = it.now_ms - ph_start;
				// a pending entry fires in any phase and leaves the phase alone
				if (entry_pend) begin
					fill_tgt = clamp_target(it.position, fill_vol);
					add_cmd_set(PROF_FILL, fill_tgt, fill_traj);
					entry_pend = 1'b0;
				end
				if (ph == PH_FILL) begin
					av = (it.velocity < 0) ? -longint'(it.velocity) : longint'(it.velocity);
					ad = longint'(it.position) - longint'(fill_tgt);
					if (ad < 0)
						ad = -ad;
					if (av <= VEL_LOW_MAX && elapsed > SETTLE_MS && ad < POS_CLOSE_LIM) begin
						ph = PH_PACK;
						ph_start = it.now_ms;
						pack_tgt = clamp_target(it.position, pack_vol);
						add_cmd_set(PROF_PACK, pack_tgt, pack_traj);
					end else if (elapsed > FILL_TIMEOUT_MS) begin
						err_flag = 1'b1;
						done_flag = 1'b1;
						cmd_batch.push_back(cmd_beat(CMD_MOVE, PROF_STOP, '0, '0));
						fin = 1'b1;
					end
				end else if (ph == PH_PACK) begin
					if (elapsed >= {16'd0, pack_ms}) begin
						ph = PH_DONE;
						done_flag = 1'b1;
						fin = 1'b1;
					end
				end else begin
					fin = done_flag;
				end
			end
			default: ;
		endcase
		if (cmd_batch.size() == 0)
			cmd_batch.push_back(cmd_beat(CMD_NONE, PROF_FILL, '0, '0));
		foreach (cmd_batch[k]) begin
			cmd_batch[k].phase = ph;
			cmd_batch[k].finished = fin;
			cmd_batch[k].complete_ok = done_flag && !err_flag;
			cmd_batch[k].error = err_flag;
			cmd_batch[k].last = (k == cmd_batch.size() - 1);
			cmd_expect_q.push_back(cmd_batch[k]);
		end
		cmd_batch.delete();
	endtask

	task automatic check_beat(ifps_out_t got);
		ifps_out_t want;
		if (cmd_expect_q.size() == 0) begin
			report_mismatch("beat with nothing expected", got, '0);
		end else begin
			want = cmd_expect_q.pop_front();
			if (got.cmd_kind !== want.cmd_kind)
				report_mismatch("cmd_kind", got.cmd_kind, want.cmd_kind);
			if (got.profile !== want.profile)
				report_mismatch("profile", got.profile, want.profile);
			if (got.move_target !== want.move_target)
				report_mismatch("move_target", got.move_target, want.move_target);
			if (got.traj_word !== want.traj_word)
				report_mismatch("traj_word", got.traj_word, want.traj_word);
			if (got.phase !== want.phase)
				report_mismatch("phase", got.phase, want.phase);
			if (got.finished !== want.finished)
				report_mismatch("finished", got.finished, want.finished);
			if (got.complete_ok !== want.complete_ok)
				report_mismatch("complete_ok", got.complete_ok, want.complete_ok);
			if (got.error !== want.error)
				report_mismatch("error", got.error, want.error);
			if (got.last !== want.last)
				report_mismatch("last", got.last, want.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_vol = '0;
			pack_vol = '0;
			pack_ms = '0;
			turns_vol = 24'd65536;
			pos_lim = 32'sh7FFF_FFFF;
			fill_traj = '0;
			pack_traj = '0;
			ph = PH_DONE;
			entry_pend = 1'b0;
			done_flag = 1'b0;
			err_flag = 1'b0;
			ph_start = '0;
			fill_tgt = '0;
			pack_tgt = '0;
			cmd_expect_q.delete();
			pending <= 0;
			beats_seen <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FILL_VOLUME:   fill_vol = cfg_data[23:0];
					REG_PACK_VOLUME:   pack_vol = cfg_data[23:0];
					REG_PACK_TIME:     pack_ms = cfg_data[15:0];
					REG_TURNS_PER_VOL: turns_vol = cfg_data[23:0];
					REG_POS_LIMIT:     pos_lim = cfg_data[31:0];
					REG_FILL_TRAJ:     fill_traj = cfg_data[47:0];
					REG_PACK_TRAJ:     pack_traj = cfg_data[47:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				check_beat(out_data);
				beats_seen <= beats_seen + 1;
			end
			if (in_valid && !in_stall)
				predict_cmds(in_data);
			pending <= cmd_expect_q.size();
		end
	end

endmodule

/* tb/injection_fill_pack_sequencer_top_test.sv */
// Top of the injection fill/pack sequencer testbench: clock, reset, stimulus, verdict.
// Depends on ifps_pkg, ifps_cmd_checker and injection_fill_pack_sequencer_top.
`timescale 1ns / 1ps

module injection_fill_pack_sequencer_top_test;
	import ifps_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [2:0]            cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	ifps_in_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	ifps_out_t             out_data;

	int fail_count, pending, beats_seen;
	int items_sent = 0;
	int burst_left = 0;
	int cycle_cnt = 0;
	bit hold_req = 1'b0;

	// stimulus-side copy of the registers that steer the shot generator
	logic [23:0]        cur_fill_vol = '0;
	logic [23:0]        cur_tpv = 24'd65536;
	logic signed [31:0] cur_lim = 32'sh7FFF_FFFF;
	logic [15:0]        cur_pack_ms = '0;

	injection_fill_pack_sequencer_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	ifps_cmd_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.fail_count (fail_count),
		.pending    (pending),
		.beats_seen (beats_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver: stall modes of random length, plus one long hold-off on request
	initial begin : rx_stall
		int mode, mode_left, hold_left, tick;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 150;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(10, 80);
				end
				mode_left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= (tick % 3 == 0);
				endcase
			end
		end
	end

	function automatic ifps_in_t mk(logic [1:0] k, logic [31:0] t, logic signed [31:0] p,
			logic signed [31:0] v);
		ifps_in_t it;
		it.kind = k;
		it.now_ms = t;
		it.position = p;
		it.velocity = v;
		return it;
	endfunction

	function automatic logic signed [31:0] rand_vel(bit low);
		if (!low)
			return $urandom;
		case ($urandom_range(0, 5))
			0: return 32'sd6553;
			1: return -32'sd6553;
			default: return int'($urandom_range(0, 13106)) - 6553;
		endcase
	endfunction

	function automatic logic signed [31:0] near_aim(logic signed [31:0] a, bit close);
		longint off, v;
		case ($urandom_range(0, 5))
			0: off = 65535;
			1: off = -65535;
			2: off = close ? 0 : 65536;
			default: off = close ? longint'($urandom_range(0, 131070)) - 65535
				: longint'($urandom_range(0, 600000)) - 300000;
		endcase
		v = longint'(a) + off;
		if (v > 64'sh7FFF_FFFF)
			v = 64'sh7FFF_FFFF;
		if (v < -64'sh8000_0000)
			v = -64'sh8000_0000;
		return v[31:0];
	endfunction

	// one beat on the input channel, with burst/gap shaping on the sender side
	task automatic offer(ifps_in_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic wr_reg(logic [2:0] idx, logic [47:0] d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FILL_VOLUME:   cur_fill_vol = d[23:0];
			REG_TURNS_PER_VOL: cur_tpv = d[23:0];
			REG_POS_LIMIT:     cur_lim = d[31:0];
			REG_PACK_TIME:     cur_pack_ms = d[15:0];
			default: ;
		endcase
	endtask

	task automatic load_setting(logic [23:0] fv, logic [23:0] pv, logic [15:0] pms,
			logic [23:0] tpv, logic signed [31:0] lim, logic [47:0] ftr, logic [47:0] ptr);
		wr_reg(REG_FILL_VOLUME, {24'd0, fv});
		wr_reg(REG_PACK_VOLUME, {24'd0, pv});
		wr_reg(REG_PACK_TIME, {32'd0, pms});
		wr_reg(REG_TURNS_PER_VOL, {24'd0, tpv});
		wr_reg(REG_POS_LIMIT, {16'd0, lim});
		wr_reg(REG_FILL_TRAJ, ftr);
		wr_reg(REG_PACK_TRAJ, ptr);
		// let the registered volume products take up the last write
		@(posedge clk);
	endtask

	// a mostly well-formed shot: begin, entry, filling, settle, packing, done
	task automatic run_shot();
		logic [31:0]        t_shot, t_now, pack_start;
		logic signed [31:0] p0, aim;
		logic [47:0]        prod;
		longint             tgt;
		t_now = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2000)
			: $urandom;
		t_shot = t_now;
		offer(mk(KIND_BEGIN, t_now, $urandom, $urandom));
		p0 = $urandom_range(0, 1) ? $urandom : int'($urandom_range(0, 2000000)) - 1000000;
		prod = cur_fill_vol * cur_tpv;
		tgt = longint'(p0) + longint'(prod[47:16]);
		if (tgt > longint'(cur_lim))
			tgt = longint'(cur_lim);
		aim = tgt[31:0];
		t_now += $urandom_range(0, 100);
		offer(mk(KIND_UPDATE, t_now, p0, rand_vel($urandom_range(0, 1))));
		repeat ($urandom_range(0, 4)) begin
			t_now += $urandom_range(1, 300);
			offer(mk(KIND_UPDATE, t_now, near_aim(aim, 1'b0), rand_vel($urandom_range(0, 1))));
		end
		if ($urandom_range(0, 5) == 0) begin
			// run past the fill timeout, sometimes twice
			repeat ($urandom_range(1, 2)) begin
				t_now = t_shot + 32'd30001 + $urandom_range(0, 500);
				offer(mk(KIND_UPDATE, t_now, near_aim(aim, 1'b0), rand_vel(1'b0)));
			end
		end
		if ($urandom_range(0, 7) == 0)
			return;
		if (t_now - t_shot <= 32'd500)
			t_now = t_shot + 32'd501 + $urandom_range(0, 50);
		pack_start = t_now;
		offer(mk(KIND_UPDATE, t_now, near_aim(aim, 1'b1), rand_vel(1'b1)));
		repeat ($urandom_range(0, 3)) begin
			t_now += $urandom_range(0, cur_pack_ms / 4);
			offer(mk(KIND_UPDATE, t_now, $urandom, $urandom));
		end
		t_now = pack_start + cur_pack_ms + $urandom_range(0, 3);
		offer(mk(KIND_UPDATE, t_now, $urandom, $urandom));
		repeat ($urandom_range(0, 2)) begin
			t_now += $urandom_range(0, 1000);
			offer(mk(KIND_UPDATE, t_now, $urandom, $urandom));
		end
	endtask

	task automatic run_phase(int count);
		int goal;
		goal = items_sent + count;
		while (items_sent < goal) begin
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 3))
					offer(mk($urandom_range(0, 3), $urandom, $urandom, $urandom));
			end else begin
				run_shot();
			end
		end
	endtask

	initial begin : stim
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, registers at reset values
		offer(mk(KIND_UPDATE, 32'd10, 32'sd0, 32'sd0));           // idle after reset
		offer(mk(KIND_UNUSED, '1, '1, '1));
		offer(mk(KIND_RESET, 32'd20, 32'sd5, 32'sd5));
		offer(mk(KIND_UPDATE, 32'd30, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF)); // entry while done
		offer(mk(KIND_BEGIN, 32'hFFFF_FF00, 32'sh8000_0000, 32'sh8000_0000));
		// entry and pack in one update, across the timestamp wrap
		offer(mk(KIND_UPDATE, 32'h0000_0100, 32'sh8000_0000, 32'sd0));
		offer(mk(KIND_UPDATE, 32'h0000_0100, 32'sd0, 32'sd0));     // zero pack time
		offer(mk(KIND_UPDATE, 32'h0000_0200, 32'sd0, 32'sd0));     // done, complete
		offer(mk(KIND_BEGIN, 32'd1000, 32'sd0, 32'sd0));
		offer(mk(KIND_UPDATE, 32'd1001, 32'sd0, 32'sd6554));
		offer(mk(KIND_UPDATE, 32'd1500, 32'sd0, 32'sd0));          // settle time not passed
		offer(mk(KIND_UPDATE, 32'd1501, 32'sd65536, 32'sd0));      // one turn off
		offer(mk(KIND_UPDATE, 32'd1502, -32'sd65535, -32'sd6553)); // just settles
		offer(mk(KIND_UPDATE, 32'd1502, 32'sd0, 32'sd0));
		offer(mk(KIND_BEGIN, 32'd5000, 32'sd0, 32'sd0));
		offer(mk(KIND_UPDATE, 32'd5000, 32'sd123456, 32'sd100000));
		offer(mk(KIND_UPDATE, 32'd35000, 32'sd0, 32'sd100000));    // timeout boundary
		offer(mk(KIND_UPDATE, 32'd35001, 32'sd0, 32'sd100000));    // fill timeout
		offer(mk(KIND_UPDATE, 32'd36000, 32'sd0, -32'sd6554));     // stop again
		offer(mk(KIND_UPDATE, 32'd36001, 32'sd123456, 32'sd0));    // settles after timeout
		offer(mk(KIND_BEGIN, 32'd0, 32'sd0, 32'sd0));
		offer(mk(KIND_UPDATE, 32'd40000, 32'sd7, 32'sd99999));     // entry then stop
		offer(mk(KIND_RESET, '1, 32'sd0, 32'sd0));
		offer(mk(KIND_UPDATE, 32'd12, -32'sd1, 32'sd1));           // entry after reset item

		// maximum volumes and hold time: targets clamp
		wait_drained();
		load_setting('1, '1, 16'hFFFF, '1, 32'sd1 + $signed({1'b0, $urandom_range(0, 32'h7FFF_FFFE)}),
			'1, '1);
		run_phase(60);

		// typical shot with the long output hold at the start
		wait_drained();
		load_setting($urandom_range(0, 24'h3_FFFF), $urandom_range(0, 24'h1_FFFF),
			$urandom_range(0, 300), 24'd65536, 32'sh7FFF_FFFF,
			{$urandom, $urandom}, {$urandom, $urandom});
		hold_req = 1'b1;
		run_phase(60);

		// all zero, limit at the bottom of the range
		wait_drained();
		load_setting('0, '0, '0, '0, 32'sh8000_0000, '0, '0);
		run_phase(60);

		wait_drained();
		load_setting($urandom, $urandom, $urandom, $urandom, $urandom,
			{$urandom, $urandom}, {$urandom, $urandom});
		run_phase(60);

		wait_drained();
		repeat (12) @(posedge clk);
		$display("Run covered %0d input beats and %0d command beats over five register settings,",
			items_sent, beats_seen);
		$display("with sender bursts, receiver stall patterns and one long output hold.");
		if (fail_count == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hdl
hdl/ifps_pkg.sv
hdl/ifps_cfg.sv
hdl/ifps_front.sv
hdl/ifps_queue.sv
hdl/ifps_back.sv
hdl/injection_fill_pack_sequencer_top.sv
tb/ifps_cmd_checker.sv
tb/injection_fill_pack_sequencer_top_test.sv
